>>> hdl/svge_pkg.sv
// State vector gate engine: shared constants, opcodes and FSM state codes.
// No dependencies; used by state_vector_gate_engine.
package svge_pkg;

  localparam int NUM_QUBITS = 10;
  localparam int AMP_WIDTH  = 32;
  localparam int IDX_W      = NUM_QUBITS;
  localparam int FIELD_W    = 10;
  localparam int CMP_W      = (NUM_QUBITS > FIELD_W) ? NUM_QUBITS : FIELD_W;
  localparam int IO_W       = 32;
  localparam int COEF_W     = 32;
  localparam int FRAC       = 30;
  localparam int PROD_W     = COEF_W + AMP_WIDTH;
  localparam int ACC_W      = PROD_W + 2;
  localparam int NUM_CFG    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int WORD_W     = 2 * AMP_WIDTH;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_GENERAL = 3'd2,
    OP_DIAG    = 3'd3,
    OP_X       = 3'd4,
    OP_Z       = 3'd5,
    OP_SWAP    = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_READ = 9'b000000010,
    ST_SCAN = 9'b000000100,
    ST_CAPX = 9'b000001000,
    ST_CAPY = 9'b000010000,
    ST_MUL  = 9'b000100000,
    ST_WRA  = 9'b001000000,
    ST_WRB  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

endpackage

>>> hdl/state_vector_gate_engine.sv
// State vector gate engine: 2^N complex amplitude store and a sequencer for one-qubit gates and swap.
// Depends on svge_pkg.
//
// Usage: requests arrive on the input channel (in_valid_i / in_stall_o) and each one
// gives exactly one result on the output channel (out_valid_o / out_stall_i).
// Write stores one amplitude and answers zero; read answers the stored amplitude;
// a gate request with valid targets sweeps the whole store once. The user must
// write the matrix registers on the cfg port only while the block is idle; the
// block itself does not enforce this. A gate sweep visits every index of the 2^N
// store in turn and, for every index that is changed, does its memory reads and
// write-backs: Z negates, X and swap exchange the pair, and diagonal and general
// matrices form their products one by one through the one 32x32 multiplier (16
// for a general matrix). The store is a single memory with one read and one write
// port; that port pair and the shared multiplier set the rate. One request is in
// work at a time. An ignored request, such as a gate with a bad target, answers zero.
// Reset clears the control logic and the matrix to identity; the store is not
// cleared and holds no defined value until written.
// A finished result waits in the output register while the receiver stalls; the
// next request is taken meanwhile and its own result waits for that register.
module state_vector_gate_engine (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [2:0]                               opcode_i,
  input  logic [3:0]                               target_a_i,
  input  logic [3:0]                               target_b_i,
  input  logic [svge_pkg::FIELD_W-1:0]             ctrl_mask_i,
  input  logic [svge_pkg::FIELD_W-1:0]             amp_index_i,
  input  logic signed [svge_pkg::IO_W-1:0]         amp_re_in_i,
  input  logic signed [svge_pkg::IO_W-1:0]         amp_im_in_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [svge_pkg::IO_W-1:0]         amp_re_out_o,
  output logic signed [svge_pkg::IO_W-1:0]         amp_im_out_o,
  output logic                                     saturated_o,
  input  logic                                     cfg_we_i,
  input  logic [svge_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic signed [svge_pkg::COEF_W-1:0]       cfg_data_i
);

  localparam int AW = svge_pkg::AMP_WIDTH;
  localparam int IW = svge_pkg::IDX_W;
  localparam int ACW = svge_pkg::ACC_W;
  localparam logic signed [svge_pkg::IO_W-1:0] IO_AMP_MAX =
    svge_pkg::IO_W'({1'b0, {(AW-1){1'b1}}});
  localparam logic signed [svge_pkg::IO_W-1:0] IO_AMP_MIN = ~IO_AMP_MAX;
  localparam logic signed [ACW-1:0] ACC_MAX = ACW'({1'b0, {(AW-1){1'b1}}});
  localparam logic signed [ACW-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [ACW-1:0] ACC_RND = ACW'(1) << (svge_pkg::FRAC - 1);
  localparam logic signed [AW-1:0]  AMP_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0]  AMP_MIN = {1'b1, {(AW-1){1'b0}}};

  function automatic logic [AW-1:0] sat_io(input logic signed [svge_pkg::IO_W-1:0] v);
    logic signed [svge_pkg::IO_W-1:0] r;
    r = v;
    if (v > IO_AMP_MAX) r = IO_AMP_MAX;
    if (v < IO_AMP_MIN) r = IO_AMP_MIN;
    return r[AW-1:0];
  endfunction

  // amplitude store
  logic [svge_pkg::WORD_W-1:0] mem [2**IW];
  logic [svge_pkg::WORD_W-1:0] rdata_q;
  logic                        mem_we, mem_re;
  logic [IW-1:0]               waddr, raddr;
  logic [svge_pkg::WORD_W-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_q <= mem[raddr];
  end

  // matrix registers
  logic signed [svge_pkg::COEF_W-1:0] m_q [svge_pkg::NUM_CFG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < svge_pkg::NUM_CFG; i++) m_q[i] <= '0;
      m_q[0] <= svge_pkg::COEF_ONE;
      m_q[6] <= svge_pkg::COEF_ONE;
    end else if (cfg_we_i) begin
      m_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  svge_pkg::state_e state_q, state_d;
  svge_pkg::op_e    op_q, op_d;
  logic [3:0]       ta_q, ta_d, tb_q, tb_d;
  logic [svge_pkg::FIELD_W-1:0] mask_q, mask_d;
  logic [IW-1:0]    idx_q, idx_d, c_q, c_d, b_q, b_d;
  logic             row_q, row_d;
  logic [svge_pkg::WORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [3:0]       s_q, s_d;
  logic             iss_q, iss_d, pv_q, pv_d;
  logic signed [svge_pkg::PROD_W-1:0] prod_q, prod_d;
  logic             pneg_q, pneg_d, plast_q, plast_d;
  logic [1:0]       pj_q, pj_d;
  logic signed [ACW-1:0] acc_q, acc_d;
  logic [AW-1:0]    res_q [4];
  logic [AW-1:0]    res_d [4];
  logic             sat_q, sat_d;
  logic             out_valid_q, out_valid_d;
  logic signed [svge_pkg::IO_W-1:0] out_re_q, out_re_d, out_im_q, out_im_d;
  logic             out_sat_q, out_sat_d;

  logic in_acc, out_free;
  assign in_stall_o = (state_q != svge_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // sweep decode
  logic [svge_pkg::CMP_W-1:0] cx, mx;
  logic [IW-1:0] ma, mb, partner;
  logic ok, abit, bbit, act, pair, gen, last_c;
  assign cx      = svge_pkg::CMP_W'(c_q);
  assign mx      = svge_pkg::CMP_W'(mask_q);
  assign ok      = (cx & mx) == mx;
  assign ma      = IW'(1) << ta_q;
  assign mb      = IW'(1) << tb_q;
  assign abit    = |(c_q & ma);
  assign bbit    = |(c_q & mb);
  assign partner = (op_q == svge_pkg::OP_SWAP) ? ((c_q ^ ma) | mb) : (c_q | ma);
  assign pair    = (op_q == svge_pkg::OP_GENERAL) || (op_q == svge_pkg::OP_X) ||
                   (op_q == svge_pkg::OP_SWAP);
  assign gen     = (op_q == svge_pkg::OP_GENERAL);
  assign last_c  = (c_q == {IW{1'b1}});

  always_comb begin
    case (op_q)
      svge_pkg::OP_GENERAL, svge_pkg::OP_X: act = !abit && ok;
      svge_pkg::OP_DIAG:                    act = ok;
      svge_pkg::OP_Z:                       act = abit && ok;
      svge_pkg::OP_SWAP:                    act = abit && !bbit && ok;
      default:                              act = 1'b0;
    endcase
  end

  // product step select: output j, term (column, re/im part)
  logic [1:0] sj;
  logic       scol, spart, srow, slast, sfinal, sneg;
  logic [2:0] cidx;
  logic [svge_pkg::WORD_W-1:0] sv;
  logic signed [AW-1:0] opnd;
  assign sj     = gen ? s_q[3:2] : {1'b0, s_q[1]};
  assign scol   = gen ? s_q[1] : 1'b0;
  assign spart  = s_q[0];
  assign srow   = gen ? sj[1] : row_q;
  // diagonal picks m00 or m11, both coefficient indexes from the target bit
  assign cidx   = gen ? {srow, scol, spart} : {row_q, row_q, spart};
  assign sv     = scol ? y_q : x_q;
  assign opnd   = (spart == sj[0]) ? sv[2*AW-1:AW] : sv[AW-1:0];
  assign sneg   = !sj[0] && spart;
  assign slast  = gen ? (s_q[1:0] == 2'b11) : s_q[0];
  assign sfinal = gen ? (s_q == 4'd15) : (s_q == 4'd3);

  // accumulate, round, saturate
  logic signed [ACW-1:0] sum, shr;
  logic [AW-1:0] rnd_val;
  logic          rnd_sat;
  assign sum = pneg_q ? (acc_q - ACW'(prod_q)) : (acc_q + ACW'(prod_q));
  assign shr = sum >>> svge_pkg::FRAC;
  always_comb begin
    rnd_val = shr[AW-1:0];
    rnd_sat = 1'b0;
    if (shr > ACC_MAX) begin
      rnd_val = AMP_MAX;
      rnd_sat = 1'b1;
    end else if (shr < ACC_MIN) begin
      rnd_val = AMP_MIN;
      rnd_sat = 1'b1;
    end
  end

  // Z negation with saturation
  logic [AW-1:0] zre, zim;
  logic          zsat;
  assign zre  = (x_q[2*AW-1:AW] == AMP_MIN) ? AMP_MAX : (AW'(0) - x_q[2*AW-1:AW]);
  assign zim  = (x_q[AW-1:0] == AMP_MIN) ? AMP_MAX : (AW'(0) - x_q[AW-1:0]);
  assign zsat = (x_q[2*AW-1:AW] == AMP_MIN) || (x_q[AW-1:0] == AMP_MIN);

  always_comb begin
    state_d = state_q;  op_d = op_q;  ta_d = ta_q;  tb_d = tb_q;
    mask_d = mask_q;  idx_d = idx_q;  c_d = c_q;  b_d = b_q;  row_d = row_q;
    x_d = x_q;  y_d = y_q;  s_d = s_q;  iss_d = iss_q;  pv_d = 1'b0;
    prod_d = prod_q;  pneg_d = pneg_q;  plast_d = plast_q;  pj_d = pj_q;
    acc_d = acc_q;  sat_d = sat_q;
    for (int i = 0; i < 4; i++) res_d[i] = res_q[i];
    out_valid_d = out_valid_q;  out_re_d = out_re_q;  out_im_d = out_im_q;
    out_sat_d = out_sat_q;
    mem_we = 1'b0;  mem_re = 1'b0;
    waddr = c_q;  raddr = c_q;  wdata = y_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      svge_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_d   = svge_pkg::op_e'(opcode_i);
          ta_d   = target_a_i;
          tb_d   = target_b_i;
          mask_d = ctrl_mask_i;
          idx_d  = IW'(amp_index_i);
          c_d    = '0;
          sat_d  = 1'b0;
          case (svge_pkg::op_e'(opcode_i))
            svge_pkg::OP_WRITE: begin
              mem_we  = 1'b1;
              waddr   = IW'(amp_index_i);
              wdata   = {sat_io(amp_re_in_i), sat_io(amp_im_in_i)};
              state_d = svge_pkg::ST_DONE;
            end
            svge_pkg::OP_READ: state_d = svge_pkg::ST_READ;
            svge_pkg::OP_GENERAL, svge_pkg::OP_DIAG, svge_pkg::OP_X,
            svge_pkg::OP_Z: begin
              state_d = (32'(target_a_i) < svge_pkg::NUM_QUBITS) ?
                        svge_pkg::ST_SCAN : svge_pkg::ST_DONE;
            end
            svge_pkg::OP_SWAP: begin
              state_d = (32'(target_a_i) < svge_pkg::NUM_QUBITS &&
                         32'(target_b_i) < svge_pkg::NUM_QUBITS) ?
                        svge_pkg::ST_SCAN : svge_pkg::ST_DONE;
            end
            default: state_d = svge_pkg::ST_DONE;
          endcase
        end
      end
      svge_pkg::ST_READ: begin
        mem_re  = 1'b1;
        raddr   = idx_q;
        state_d = svge_pkg::ST_DONE;
      end
      svge_pkg::ST_SCAN: begin
        mem_re = 1'b1;
        raddr  = c_q;
        if (act) begin
          b_d     = partner;
          row_d   = abit;
          state_d = svge_pkg::ST_CAPX;
        end else if (last_c) begin
          state_d = svge_pkg::ST_DONE;
        end else begin
          c_d = c_q + IW'(1);
        end
      end
      svge_pkg::ST_CAPX: begin
        x_d = rdata_q;
        if (pair) begin
          mem_re  = 1'b1;
          raddr   = b_q;
          state_d = svge_pkg::ST_CAPY;
        end else if (op_q == svge_pkg::OP_DIAG) begin
          s_d = '0;  iss_d = 1'b1;  acc_d = ACC_RND;
          state_d = svge_pkg::ST_MUL;
        end else begin
          state_d = svge_pkg::ST_WRA;
        end
      end
      svge_pkg::ST_CAPY: begin
        y_d = rdata_q;
        if (gen) begin
          s_d = '0;  iss_d = 1'b1;  acc_d = ACC_RND;
          state_d = svge_pkg::ST_MUL;
        end else begin
          state_d = svge_pkg::ST_WRA;
        end
      end
      svge_pkg::ST_MUL: begin
        if (iss_q) begin
          prod_d  = m_q[cidx] * opnd;
          pneg_d  = sneg;
          plast_d = slast;
          pj_d    = sj;
          pv_d    = 1'b1;
          s_d     = s_q + 4'd1;
          if (sfinal) iss_d = 1'b0;
        end
        if (pv_q) begin
          if (plast_q) begin
            res_d[pj_q] = rnd_val;
            sat_d       = sat_q | rnd_sat;
            acc_d       = ACC_RND;
          end else begin
            acc_d = sum;
          end
          if (!iss_q) state_d = svge_pkg::ST_WRA;
        end
      end
      svge_pkg::ST_WRA: begin
        mem_we = 1'b1;
        waddr  = c_q;
        case (op_q)
          svge_pkg::OP_Z: begin
            wdata = {zre, zim};
            sat_d = sat_q | zsat;
          end
          svge_pkg::OP_GENERAL, svge_pkg::OP_DIAG: wdata = {res_q[0], res_q[1]};
          default: wdata = y_q;
        endcase
        if (pair) state_d = svge_pkg::ST_WRB;
        else if (last_c) state_d = svge_pkg::ST_DONE;
        else begin
          c_d     = c_q + IW'(1);
          state_d = svge_pkg::ST_SCAN;
        end
      end
      svge_pkg::ST_WRB: begin
        mem_we = 1'b1;
        waddr  = b_q;
        wdata  = gen ? {res_q[2], res_q[3]} : x_q;
        if (last_c) state_d = svge_pkg::ST_DONE;
        else begin
          c_d     = c_q + IW'(1);
          state_d = svge_pkg::ST_SCAN;
        end
      end
      svge_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sat_d   = sat_q;
          if (op_q == svge_pkg::OP_READ) begin
            out_re_d = svge_pkg::IO_W'($signed(rdata_q[2*AW-1:AW]));
            out_im_d = svge_pkg::IO_W'($signed(rdata_q[AW-1:0]));
          end else begin
            out_re_d = '0;
            out_im_d = '0;
          end
          state_d = svge_pkg::ST_IDLE;
        end
      end
      default: state_d = svge_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svge_pkg::ST_IDLE;
      iss_q       <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  ta_q <= ta_d;  tb_q <= tb_d;  mask_q <= mask_d;
    idx_q <= idx_d;  c_q <= c_d;  b_q <= b_d;  row_q <= row_d;
    x_q <= x_d;  y_q <= y_d;  s_q <= s_d;
    prod_q <= prod_d;  pneg_q <= pneg_d;  plast_q <= plast_d;  pj_q <= pj_d;
    acc_q <= acc_d;  sat_q <= sat_d;
    for (int i = 0; i < 4; i++) res_q[i] <= res_d[i];
    out_re_q <= out_re_d;  out_im_q <= out_im_d;  out_sat_q <= out_sat_d;
  end

  assign out_valid_o  = out_valid_q;
  assign amp_re_out_o = out_re_q;
  assign amp_im_out_o = out_im_q;
  assign saturated_o  = out_sat_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != svge_pkg::ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == svge_pkg::ST_DONE))
    else $error("result appeared outside the done state");

  a_product_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> state_q == svge_pkg::ST_MUL)
    else $error("pending product outside multiply state");

endmodule
